@@ hdl/best_fit_extent_allocator_defines.svh @@
// Assertion macros used by the allocator controller.
`ifndef BEST_FIT_EXTENT_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_EXTENT_ALLOCATOR_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define BFEA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define BFEA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bfea_pkg.sv @@
package bfea_pkg;

  localparam int MaxExtents  = 64;
  localparam int AddrBits    = 24;
  localparam int HeaderBytes = 8;
  localparam int IdxBits     = $clog2(MaxExtents);
  localparam int CntBits     = 7;
  localparam int AgeBits     = 16;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_ADD   = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_DUP  = 2'd3;

  localparam logic [AddrBits-1:0] AddrMax = '1;

  // One table entry as it moves along the ring of cells.
  typedef struct packed {
    logic                valid;
    logic [AddrBits-1:0] start;
    logic [AddrBits-1:0] len;
    logic [AgeBits-1:0]  age;
  } entry_t;

  // Write command applied to the entry leaving the last cell.
  typedef struct packed {
    logic                en;
    logic                valid;
    logic [AddrBits-1:0] start;
    logic [AddrBits-1:0] len;
    logic                stamp;
  } upd_t;

endpackage

@@ hdl/bfea_cell.sv @@
module bfea_cell
  import bfea_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   clear,
  input  entry_t din,
  output entry_t dout
);

  // One slot of the ring; all cells shift together every cycle.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.start <= din.start;
    dout.len   <= din.len;
    dout.age   <= din.age;
  end

endmodule

@@ hdl/bfea_ctrl.sv @@
`include "best_fit_extent_allocator_defines.svh"
module bfea_ctrl
  import bfea_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          op_in,
  input  logic [AddrBits-1:0] off_in,
  input  logic [AddrBits-1:0] len_in,
  input  entry_t              tail,
  output entry_t              head,
  output logic                clear,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [1:0]          status,
  output logic [AddrBits-1:0] granted,
  output logic [AddrBits-1:0] largest,
  output logic [CntBits-1:0]  count
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_STAT = 2'd3;

  localparam logic [AddrBits:0] NeedAdd = (AddrBits+1)'(HeaderBytes);

  logic [1:0]          state;
  logic [IdxBits-1:0]  pos;
  logic [1:0]          op;
  logic [AddrBits-1:0] off, len;
  logic [AgeBits-1:0]  age_counter;

  // Scan results, recorded as ring positions.
  logic                have_slot, have_dup, have_best, have_pr, have_nx;
  logic [IdxBits-1:0]  slot_pos, best_pos, pr_pos, nx_pos;
  logic [AddrBits-1:0] best_len, pr_start, pr_len, nx_start, nx_len, best_start;
  logic [AgeBits-1:0]  best_dist;

  // Decided updates.
  upd_t                upd_a, upd_b;
  logic [IdxBits-1:0]  pos_a, pos_b;

  logic [AddrBits:0]   need;
  logic [AddrBits:0]   full_raw;
  logic [AddrBits-1:0] full;
  logic [AgeBits-1:0]  age_gap;
  logic                fits, better;

  assign need     = {1'b0, len} + NeedAdd;
  assign full_raw = need;
  assign full     = full_raw[AddrBits] ? AddrMax : full_raw[AddrBits-1:0];
  assign age_gap  = age_counter - tail.age;
  assign fits     = tail.valid && ({1'b0, tail.len} >= need);
  assign better   = !have_best || tail.len < best_len ||
                    (tail.len == best_len && age_gap > best_dist);

  // A new request starts only when entry zero is the next one to reach the tail.
  assign in_ready = (state == S_IDLE) && !res_valid && (pos == '1);
  // Clearing empties every cell in the decision cycle, before the write-back pass.
  assign clear    = (state == S_STAT) && (op == OP_CLEAR);

  function automatic logic [AddrBits-1:0] sat_add3(
    input logic [AddrBits-1:0] a, input logic [AddrBits-1:0] b,
    input logic [AddrBits-1:0] c);
    logic [AddrBits+1:0] s;
    begin
      s = {2'b0, a} + {2'b0, b} + {2'b0, c};
      sat_add3 = (s > {2'b0, AddrMax}) ? AddrMax : s[AddrBits-1:0];
    end
  endfunction

  // Entry re-entering the ring at the head, possibly rewritten.
  always_comb begin
    head = tail;
    if (state == S_APPLY) begin
      if (upd_a.en && pos == pos_a) begin
        head.valid = upd_a.valid;
        head.start = upd_a.start;
        head.len   = upd_a.len;
        if (upd_a.stamp) begin
          // The counter already advanced when the update was decided.
          head.age = age_counter - 1'b1;
        end
      end else if (upd_b.en && pos == pos_b) begin
        head.valid = upd_b.valid;
        head.start = upd_b.start;
        head.len   = upd_b.len;
      end
    end
  end

  logic [AddrBits:0] pr_end;
  logic [AddrBits:0] fr_end;
  logic              pj, nj;
  assign pr_end = {1'b0, pr_start} + {1'b0, pr_len};
  assign fr_end = {1'b0, off} + {1'b0, full};
  assign pj = have_pr && pr_end == {1'b0, off};
  assign nj = have_nx && fr_end == {1'b0, nx_start};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      res_valid   <= 1'b0;
      age_counter <= '0;
      pos         <= '0;
      upd_a.en    <= 1'b0;
      upd_b.en    <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      pos <= pos + 1'b1;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op <= op_in; off <= off_in; len <= len_in;
            have_slot <= 1'b0; have_dup <= 1'b0; have_best <= 1'b0;
            have_pr <= 1'b0; have_nx <= 1'b0;
            upd_a.en <= 1'b0; upd_b.en <= 1'b0;
            upd_a.stamp <= 1'b0; upd_b.stamp <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!tail.valid) begin
            if (!have_slot) begin have_slot <= 1'b1; slot_pos <= pos; end
          end else begin
            if (tail.start == off && !have_dup) have_dup <= 1'b1;
            if (fits && better) begin
              have_best <= 1'b1; best_pos <= pos; best_len <= tail.len;
              best_dist <= age_gap; best_start <= tail.start;
            end
            if (tail.start <= off) begin
              if (!have_pr || tail.start > pr_start) begin
                have_pr <= 1'b1; pr_pos <= pos;
                pr_start <= tail.start; pr_len <= tail.len;
              end
            end else if (!have_nx || tail.start < nx_start) begin
              have_nx <= 1'b1; nx_pos <= pos;
              nx_start <= tail.start; nx_len <= tail.len;
            end
          end
          if (pos == '1) begin
            state <= S_STAT;
            status  <= ST_OK;
            granted <= '0;
          end
        end
        S_STAT: begin
          // Decide the operation while entry zero passes unchanged.
          state <= S_APPLY;
          largest <= '0; count <= '0;
          case (op)
            OP_ALLOC: begin
              if (!have_best) begin
                status <= ST_NOFIT;
              end else begin
                granted <= best_start;
                upd_a.en <= 1'b1; pos_a <= best_pos;
                if ({1'b0, best_len} != need) begin
                  upd_a.valid <= 1'b1;
                  upd_a.start <= best_start + need[AddrBits-1:0];
                  upd_a.len   <= best_len - need[AddrBits-1:0];
                  upd_a.stamp <= 1'b1;
                  age_counter <= age_counter + 1'b1;
                end else begin
                  upd_a.valid <= 1'b0;
                end
              end
            end
            OP_FREE: begin
              if (have_dup && !pj) begin
                status <= ST_DUP;
              end else if (pj) begin
                upd_a.en <= 1'b1; pos_a <= pr_pos; upd_a.valid <= 1'b1;
                upd_a.start <= pr_start; upd_a.stamp <= 1'b1;
                age_counter <= age_counter + 1'b1;
                if (nj) begin
                  upd_a.len <= sat_add3(pr_len, full, nx_len);
                  upd_b.en <= 1'b1; pos_b <= nx_pos; upd_b.valid <= 1'b0;
                  upd_b.start <= nx_start; upd_b.len <= nx_len;
                end else begin
                  upd_a.len <= sat_add3(pr_len, full, '0);
                end
              end else if (nj) begin
                upd_a.en <= 1'b1; pos_a <= nx_pos; upd_a.valid <= 1'b1;
                upd_a.start <= off; upd_a.len <= sat_add3(nx_len, full, '0);
                upd_a.stamp <= 1'b1; age_counter <= age_counter + 1'b1;
              end else if (!have_slot) begin
                status <= ST_FULL;
              end else begin
                upd_a.en <= 1'b1; pos_a <= slot_pos; upd_a.valid <= 1'b1;
                upd_a.start <= off; upd_a.len <= full;
                upd_a.stamp <= 1'b1; age_counter <= age_counter + 1'b1;
              end
            end
            OP_ADD: begin
              if (have_dup) begin
                status <= ST_DUP;
              end else if (!have_slot) begin
                status <= ST_FULL;
              end else begin
                upd_a.en <= 1'b1; pos_a <= slot_pos; upd_a.valid <= 1'b1;
                upd_a.start <= off; upd_a.len <= len;
                upd_a.stamp <= 1'b1; age_counter <= age_counter + 1'b1;
              end
            end
            default: begin
              upd_a.en <= 1'b0;
            end
          endcase
        end
        S_APPLY: begin
          // Rewrite entries as they pass and sum up the new table over one
          // full turn, ending when entry zero comes around again.
          if (head.valid) begin
            count <= count + 1'b1;
            if (head.len > largest) largest <= head.len;
          end
          if (pos == '0) begin
            state <= S_IDLE;
            res_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BFEA_ASSERT_IMP(a_res_idle, res_valid, state == S_IDLE, "result shown mid-operation")
  `BFEA_ASSERT_NEXT(a_accept_clr, in_valid && in_ready, !res_valid, "result before work")
  `BFEA_ASSERT_IMP(a_cnt_rng, res_valid, count <= CntBits'(MaxExtents), "count too large")

endmodule

@@ hdl/best_fit_extent_allocator.sv @@
// A transaction is taken only when entry zero is next at the tail of the 64-cell ring,
// so s_axis_tready may stay low while the ring turns to bring it there.
// Each transaction runs a scan, a decision step and a write-back pass, one at a time.
// The result waits in an output register; the next transaction is taken after it leaves.
// Synchronous active-high rst empties the table and zeroes the age counter.
module best_fit_extent_allocator
  import bfea_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // opcode[1:0], offset[25:2], length[49:26], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // status, granted_offset, largest_free, extent_count
);

  entry_t ring [MaxExtents+1];
  entry_t head, tail;
  logic   clear;
  logic [1:0]          status;
  logic [AddrBits-1:0] granted, largest;
  logic [CntBits-1:0]  count;

  // The entries circulate through the cells; the controller closes the ring.
  assign ring[0] = head;
  assign tail    = ring[MaxExtents];

  for (genvar g = 0; g < MaxExtents; g++) begin : g_cells
    bfea_cell u_cell (
      .clk (clk),
      .rst (rst),
      .clear (clear),
      .din (ring[g]),
      .dout (ring[g+1])
    );
  end

  bfea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .op_in     (s_axis_tdata[1:0]),
    .off_in    (s_axis_tdata[25:2]),
    .len_in    (s_axis_tdata[49:26]),
    .tail      (tail),
    .head      (head),
    .clear     (clear),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .status    (status),
    .granted   (granted),
    .largest   (largest),
    .count     (count)
  );

  assign m_axis_tdata = {7'd0, count, largest, granted, status};

endmodule
